// File: sv/i2cts_pkg.sv
// Package for the I2C transfer sequencer: word types, codes, phase encoding.
// Used by the control, output and top modules; depends on nothing.
package i2cts_pkg;

  localparam int BufDepth = 256;
  localparam int BufAw = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam logic [8:0] BufDepthW = 9'(BufDepth);

  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeReq  = 2'd1;
  localparam logic [1:0] ModeCore = 2'd2;

  localparam logic [1:0] KindCmd  = 2'd0;
  localparam logic [1:0] KindRx   = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;

  localparam logic [2:0] CmdStart = 3'd0;
  localparam logic [2:0] CmdWrite = 3'd1;
  localparam logic [2:0] CmdRead  = 3'd2;
  localparam logic [2:0] CmdStop  = 3'd3;
  localparam logic [2:0] CmdOff   = 3'd4;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusNoAck = 1'b1;

  localparam logic [7:0] ReadBit = 8'h01;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_ADDR  = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_STOP  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] buffer_index;
    logic [7:0] load_byte;
    logic       is_read;
    logic [6:0] slave_addr;
    logic [7:0] byte_count;
    logic       keep_bus;
    logic       core_ack;
    logic [7:0] core_read_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [2:0] command;
    logic       send_ack;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       status;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic      two;
    logic      ram;
    out_word_t r0;
    out_word_t r1;
  } stage_t;

endpackage

// File: sv/i2cts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cts_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/i2cts_ctrl.sv
// Transfer control: phase and transfer registers, write buffer RAM, first stage.
// Depends on i2cts_pkg and i2cts_ram.
module i2cts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cts_pkg::in_word_t in_word_i,
  output logic                a_valid_o,
  output i2cts_pkg::stage_t   a_stage_o,
  output logic [7:0]          rdata_o,
  input  logic                a_take_i
);

  i2cts_pkg::phase_e phase_q, phase_d;
  logic       dir_read_q, dir_read_d;
  logic [6:0] target_addr_q, target_addr_d;
  logic [7:0] total_bytes_q, total_bytes_d;
  logic [7:0] bytes_done_q, bytes_done_d;
  logic       hold_bus_q, hold_bus_d;

  logic              a_valid_q, a_valid_d;
  i2cts_pkg::stage_t a_stage_q, a_stage_d;

  logic                       acc;
  logic                       gen;
  logic                       we, re;
  logic [i2cts_pkg::BufAw-1:0] waddr, raddr;
  logic [7:0]                 wdata;
  logic [7:0]                 bd_next;
  logic                       more;
  logic                       pos_ok;
  i2cts_pkg::out_word_t       data_word, close_word;
  i2cts_pkg::phase_e          close_phase;

  assign acc     = in_valid_i && !in_stall_o;
  assign bd_next = 8'(bytes_done_q + 8'd1);
  assign more    = bd_next < total_bytes_q;

  always_comb begin
    close_word  = '0;
    close_word.last = 1'b1;
    if (hold_bus_q) begin
      close_word.result_kind = i2cts_pkg::KindDone;
      close_word.status      = i2cts_pkg::StatusOk;
      close_phase            = i2cts_pkg::PH_IDLE;
    end else begin
      close_word.result_kind = i2cts_pkg::KindCmd;
      close_word.command     = i2cts_pkg::CmdStop;
      close_phase            = i2cts_pkg::PH_STOP;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    dir_read_d    = dir_read_q;
    target_addr_d = target_addr_q;
    total_bytes_d = total_bytes_q;
    bytes_done_d  = bytes_done_q;
    hold_bus_d    = hold_bus_q;
    gen           = 1'b0;
    a_stage_d     = a_stage_q;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = in_word_i.buffer_index[i2cts_pkg::BufAw-1:0];
    wdata         = in_word_i.load_byte;
    raddr         = bytes_done_q[i2cts_pkg::BufAw-1:0];
    data_word     = '0;
    pos_ok        = 1'b0;

    if (acc) begin
      a_stage_d = '0;
      unique case (in_word_i.mode)
        i2cts_pkg::ModeLoad: begin
          we = {1'b0, in_word_i.buffer_index} < i2cts_pkg::BufDepthW;
        end
        i2cts_pkg::ModeReq: begin
          if (phase_q == i2cts_pkg::PH_IDLE) begin
            dir_read_d    = in_word_i.is_read;
            target_addr_d = in_word_i.slave_addr;
            total_bytes_d = in_word_i.byte_count;
            hold_bus_d    = in_word_i.keep_bus;
            bytes_done_d  = '0;
            phase_d       = i2cts_pkg::PH_START;
            gen           = 1'b1;
            a_stage_d.r0.result_kind = i2cts_pkg::KindCmd;
            a_stage_d.r0.command     = i2cts_pkg::CmdStart;
            a_stage_d.r0.last        = 1'b1;
          end
        end
        i2cts_pkg::ModeCore: begin
          unique case (phase_q)
            i2cts_pkg::PH_START: begin
              gen     = 1'b1;
              phase_d = i2cts_pkg::PH_ADDR;
              a_stage_d.r0.result_kind = i2cts_pkg::KindCmd;
              a_stage_d.r0.command     = i2cts_pkg::CmdWrite;
              a_stage_d.r0.tx_byte     = {target_addr_q, 1'b0}
                                         | (dir_read_q ? i2cts_pkg::ReadBit : 8'h00);
              a_stage_d.r0.last        = 1'b1;
            end
            i2cts_pkg::PH_ADDR: begin
              gen = 1'b1;
              if (!in_word_i.core_ack) begin
                phase_d = i2cts_pkg::PH_IDLE;
                a_stage_d.r0.result_kind = i2cts_pkg::KindDone;
                a_stage_d.r0.status      = i2cts_pkg::StatusNoAck;
                a_stage_d.r0.last        = 1'b1;
              end else if (total_bytes_q == 8'd0) begin
                phase_d      = close_phase;
                a_stage_d.r0 = close_word;
              end else begin
                phase_d = i2cts_pkg::PH_DATA;
                data_word.result_kind = i2cts_pkg::KindCmd;
                data_word.last        = 1'b1;
                if (dir_read_q) begin
                  data_word.command  = i2cts_pkg::CmdRead;
                  data_word.send_ack = 8'(bytes_done_q + 8'd1) < total_bytes_q;
                end else begin
                  data_word.command = i2cts_pkg::CmdWrite;
                  pos_ok = {1'b0, bytes_done_q} < i2cts_pkg::BufDepthW;
                  re     = pos_ok;
                  raddr  = bytes_done_q[i2cts_pkg::BufAw-1:0];
                end
                a_stage_d.r0  = data_word;
                a_stage_d.ram = pos_ok;
              end
            end
            i2cts_pkg::PH_DATA: begin
              gen          = 1'b1;
              bytes_done_d = bd_next;
              data_word.result_kind = i2cts_pkg::KindCmd;
              data_word.last        = 1'b1;
              if (dir_read_q) begin
                data_word.command  = i2cts_pkg::CmdRead;
                data_word.send_ack = 8'(bd_next + 8'd1) < total_bytes_q;
              end else begin
                data_word.command = i2cts_pkg::CmdWrite;
                pos_ok = {1'b0, bd_next} < i2cts_pkg::BufDepthW;
              end
              if (!more) begin
                phase_d = close_phase;
              end
              if (dir_read_q) begin
                we    = {1'b0, bytes_done_q} < i2cts_pkg::BufDepthW;
                waddr = bytes_done_q[i2cts_pkg::BufAw-1:0];
                wdata = in_word_i.core_read_byte;
                a_stage_d.two            = 1'b1;
                a_stage_d.r0.result_kind = i2cts_pkg::KindRx;
                a_stage_d.r0.rx_byte     = in_word_i.core_read_byte;
                a_stage_d.r0.rx_index    = bytes_done_q;
                a_stage_d.r1             = more ? data_word : close_word;
              end else begin
                a_stage_d.r0  = more ? data_word : close_word;
                a_stage_d.ram = more && pos_ok;
                re            = more && pos_ok;
                raddr         = bd_next[i2cts_pkg::BufAw-1:0];
              end
            end
            i2cts_pkg::PH_STOP: begin
              gen     = 1'b1;
              phase_d = i2cts_pkg::PH_IDLE;
              a_stage_d.two            = 1'b1;
              a_stage_d.r0.result_kind = i2cts_pkg::KindCmd;
              a_stage_d.r0.command     = i2cts_pkg::CmdOff;
              a_stage_d.r1.result_kind = i2cts_pkg::KindDone;
              a_stage_d.r1.status      = i2cts_pkg::StatusOk;
              a_stage_d.r1.last        = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (acc && gen) begin
      a_valid_d = 1'b1;
    end else if (a_take_i) begin
      a_valid_d = 1'b0;
    end else begin
      a_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= i2cts_pkg::PH_IDLE;
      dir_read_q    <= 1'b0;
      target_addr_q <= '0;
      total_bytes_q <= '0;
      bytes_done_q  <= '0;
      hold_bus_q    <= 1'b0;
      a_valid_q     <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      dir_read_q    <= dir_read_d;
      target_addr_q <= target_addr_d;
      total_bytes_q <= total_bytes_d;
      bytes_done_q  <= bytes_done_d;
      hold_bus_q    <= hold_bus_d;
      a_valid_q     <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_stage_q <= a_stage_d;
  end

  i2cts_ram #(
    .Width(8),
    .Depth(i2cts_pkg::BufDepth)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_o)
  );

  assign in_stall_o = a_valid_q && !a_take_i;
  assign a_valid_o  = a_valid_q;
  assign a_stage_o  = a_stage_q;

endmodule

// File: sv/i2cts_outq.sv
// Output stage: merges buffer read data and issues one or two result words.
// Depends on i2cts_pkg.
module i2cts_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 a_valid_i,
  input  i2cts_pkg::stage_t    a_stage_i,
  input  logic [7:0]           rdata_i,
  output logic                 a_take_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cts_pkg::out_word_t out_word_o
);

  logic                 b_valid_q, b_valid_d;
  logic                 b_two_q, b_two_d;
  i2cts_pkg::out_word_t b_r0_q, b_r0_d;
  i2cts_pkg::out_word_t b_r1_q, b_r1_d;
  logic                 pop;
  logic                 b_free;

  assign pop      = b_valid_q && !out_stall_i;
  assign b_free   = !b_valid_q || (pop && !b_two_q);
  assign a_take_o = a_valid_i && b_free;

  always_comb begin
    b_valid_d = b_valid_q;
    b_two_d   = b_two_q;
    b_r0_d    = b_r0_q;
    b_r1_d    = b_r1_q;
    priority if (a_take_o) begin
      b_valid_d = 1'b1;
      b_two_d   = a_stage_i.two;
      b_r0_d    = a_stage_i.r0;
      b_r1_d    = a_stage_i.r1;
      if (a_stage_i.ram) begin
        b_r0_d.tx_byte = rdata_i;
      end
    end else if (pop && b_two_q) begin
      b_two_d = 1'b0;
      b_r0_d  = b_r1_q;
    end else if (pop) begin
      b_valid_d = 1'b0;
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_two_q   <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      b_two_q   <= b_two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_r0_q <= b_r0_d;
    b_r1_q <= b_r1_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_word_o  = b_r0_q;

endmodule

// File: sv/i2c_transfer_sequencer.sv
// I2C transfer sequencer: one input word per cycle unless in_stall_o is high; a result is
// registered in the cycle after acceptance (control stage with buffer RAM read), then
// moves into the output register, from which it can be taken.
// One result word per output cycle unless out_stall_i is high; a two-result event holds the
// output for both words while the control stage can still take the next input word.
// Reset (async, active low) returns the phase to idle and empties both stages;
// the write buffer is not cleared.
module i2c_transfer_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2cts_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cts_pkg::out_word_t out_word_o
);

  logic              a_valid;
  i2cts_pkg::stage_t a_stage;
  logic [7:0]        rdata;
  logic              a_take;

  i2cts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word_i),
    .a_valid_o (a_valid),
    .a_stage_o (a_stage),
    .rdata_o   (rdata),
    .a_take_i  (a_take)
  );

  i2cts_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .a_valid_i  (a_valid),
    .a_stage_i  (a_stage),
    .rdata_i    (rdata),
    .a_take_o   (a_take),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the I2C transfer sequencer: directed transfers, then random
// bursts of loads, requests and bus-core events against an in-bench predictor.
// Depends on i2cts_pkg and i2c_transfer_sequencer only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cts_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int RandomItems = 1900;

  class xfer_scoreboard;
    phase_e     phase;
    bit         dir_read;
    bit [6:0]   target;
    bit [7:0]   total;
    bit [7:0]   pos;
    bit         keep;
    bit [7:0]   buffer [BufDepth];
    bit         written [BufDepth];
    out_word_t  pending [$];
    int         errors;
    int         checked;
    int         transfers;
    int         nacks;

    function new();
      phase = PH_IDLE;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function out_word_t result_word(logic [1:0] kind, logic [2:0] cmd, logic ack,
                                    logic [7:0] tx, logic [7:0] rx, logic [7:0] idx,
                                    logic st, logic lst);
      out_word_t r;
      r.result_kind = kind;
      r.command     = cmd;
      r.send_ack    = ack;
      r.tx_byte     = tx;
      r.rx_byte     = rx;
      r.rx_index    = idx;
      r.status      = st;
      r.last        = lst;
      return r;
    endfunction

    function void push_data_cmd();
      if (dir_read) begin
        pending.push_back(result_word(KindCmd, CmdRead, int'(pos) + 1 < int'(total),
                                      8'h00, 8'h00, 8'h00, StatusOk, 1'b1));
      end else begin
        pending.push_back(result_word(KindCmd, CmdWrite, 1'b0, buffer[pos],
                                      8'h00, 8'h00, StatusOk, 1'b1));
      end
    endfunction

    function void close_out();
      if (keep) begin
        pending.push_back(result_word(KindDone, CmdStart, 1'b0, 8'h00, 8'h00, 8'h00,
                                      StatusOk, 1'b1));
        phase = PH_IDLE;
      end else begin
        pending.push_back(result_word(KindCmd, CmdStop, 1'b0, 8'h00, 8'h00, 8'h00,
                                      StatusOk, 1'b1));
        phase = PH_STOP;
      end
    endfunction

    // Position of the buffer byte that a core event would send, or -1.
    function int write_pos_after(bit ack);
      if (dir_read) return -1;
      if (phase == PH_ADDR && ack && total != 0) return 0;
      if (phase == PH_DATA && int'(pos) + 1 < int'(total)) return int'(pos) + 1;
      return -1;
    endfunction

    // Advance the predicted state; return 1 if the word had any effect.
    function bit note_input(in_word_t w);
      case (w.mode)
        ModeLoad: begin
          buffer[w.buffer_index]  = w.load_byte;
          written[w.buffer_index] = 1'b1;
        end
        ModeReq: begin
          if (phase != PH_IDLE) return 0;
          dir_read = w.is_read;
          target   = w.slave_addr;
          total    = w.byte_count;
          keep     = w.keep_bus;
          pos      = 8'd0;
          transfers++;
          pending.push_back(result_word(KindCmd, CmdStart, 1'b0, 8'h00, 8'h00, 8'h00,
                                        StatusOk, 1'b1));
          phase = PH_START;
        end
        ModeCore: begin
          case (phase)
            PH_START: begin
              pending.push_back(result_word(KindCmd, CmdWrite, 1'b0,
                                            {target, 1'b0} | (dir_read ? ReadBit : 8'h00),
                                            8'h00, 8'h00, StatusOk, 1'b1));
              phase = PH_ADDR;
            end
            PH_ADDR: begin
              if (!w.core_ack) begin
                pending.push_back(result_word(KindDone, CmdStart, 1'b0, 8'h00, 8'h00,
                                              8'h00, StatusNoAck, 1'b1));
                nacks++;
                phase = PH_IDLE;
              end else if (total == 0) begin
                close_out();
              end else begin
                push_data_cmd();
                phase = PH_DATA;
              end
            end
            PH_DATA: begin
              if (dir_read) begin
                buffer[pos]  = w.core_read_byte;
                written[pos] = 1'b1;
                pending.push_back(result_word(KindRx, CmdStart, 1'b0, 8'h00,
                                              w.core_read_byte, pos, StatusOk, 1'b0));
              end
              pos++;
              if (pos < total) push_data_cmd();
              else close_out();
            end
            PH_STOP: begin
              pending.push_back(result_word(KindCmd, CmdOff, 1'b0, 8'h00, 8'h00, 8'h00,
                                            StatusOk, 1'b0));
              pending.push_back(result_word(KindDone, CmdStart, 1'b0, 8'h00, 8'h00, 8'h00,
                                            StatusOk, 1'b1));
              phase = PH_IDLE;
            end
            default: return 0;
          endcase
        end
        default: return 0;
      endcase
      return 1;
    endfunction

    task check(out_word_t got);
      out_word_t e;
      string     diff;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
        return;
      end
      e = pending.pop_front();
      diff = "";
      if (got.result_kind !== e.result_kind) diff = {diff, " result_kind"};
      if (got.command !== e.command) diff = {diff, " command"};
      if (got.send_ack !== e.send_ack) diff = {diff, " send_ack"};
      if (got.tx_byte !== e.tx_byte) diff = {diff, " tx_byte"};
      if (got.rx_byte !== e.rx_byte) diff = {diff, " rx_byte"};
      if (got.rx_index !== e.rx_index) diff = {diff, " rx_index"};
      if (got.status !== e.status) diff = {diff, " status"};
      if (got.last !== e.last) diff = {diff, " last"};
      if (diff != "") begin
        report($sformatf("result %0d differs in%s: got %h want %h", checked, diff, got, e));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  bit        hold_req;
  int        items_sent;
  xfer_scoreboard sb = new();

  i2c_transfer_sequencer uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #1 clk = ~clk;

  function automatic in_word_t rand_word();
    in_word_t    w;
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    w = r[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t load_word(logic [7:0] idx, logic [7:0] b);
    in_word_t w;
    w = rand_word();
    w.mode = ModeLoad;
    w.buffer_index = idx;
    w.load_byte = b;
    return w;
  endfunction

  function automatic in_word_t req_word(logic rd, logic [6:0] addr, logic [7:0] cnt,
                                        logic kb);
    in_word_t w;
    w = rand_word();
    w.mode = ModeReq;
    w.is_read = rd;
    w.slave_addr = addr;
    w.byte_count = cnt;
    w.keep_bus = kb;
    return w;
  endfunction

  function automatic in_word_t core_word(logic ack, logic [7:0] rb);
    in_word_t w;
    w = rand_word();
    w.mode = ModeCore;
    w.core_ack = ack;
    w.core_read_byte = rb;
    return w;
  endfunction

  function automatic in_word_t mode_word(logic [1:0] m);
    in_word_t w;
    w = rand_word();
    w.mode = m;
    return w;
  endfunction

  task automatic drive_word(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    void'(sb.note_input(w));
    items_sent++;
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_step();
    in_word_t w;
    int       p;
    logic [7:0] cnt;
    if (sb.phase == PH_IDLE) begin
      case ($urandom_range(0, 19))
        0: w = mode_word(ModeCore);
        1: w = mode_word(ModeUnused);
        2, 3, 4: w = load_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: begin
          p = $urandom_range(0, 149);
          if (p == 0) cnt = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(128, 254));
          else if (p < 40) cnt = 8'($urandom_range(7, 40));
          else cnt = 8'($urandom_range(0, 6));
          w = req_word(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), cnt,
                       $urandom_range(0, 3) == 0);
        end
      endcase
    end else begin
      case ($urandom_range(0, 19))
        0: w = mode_word(ModeUnused);
        1: w = mode_word(ModeReq);
        2: w = load_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: begin
          w = core_word($urandom_range(0, 9) != 0, 8'($urandom_range(0, 255)));
          p = sb.write_pos_after(w.core_ack);
          // load a buffer byte before it is sent if it was never written
          if (p >= 0 && !sb.written[p]) begin
            drive_word(load_word(8'(p), 8'($urandom_range(0, 255))));
          end
        end
      endcase
    end
    drive_word(w);
  endtask

  initial begin
    int burst_left;
    bit held;
    bit paused;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_word(load_word(8'd0, 8'hFF));
    drive_word(load_word(8'd1, 8'h00));
    drive_word(load_word(8'd255, 8'h5A));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(mode_word(ModeUnused));
    drive_word(req_word(1'b0, 7'h7F, 8'd2, 1'b0));
    drive_word(core_word(1'b0, 8'h00));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(req_word(1'b1, 7'h00, 8'd5, 1'b1));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(req_word(1'b1, 7'h00, 8'd1, 1'b1));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(core_word(1'b1, 8'hFF));
    drive_word(req_word(1'b0, 7'h55, 8'd3, 1'b0));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(core_word(1'b0, 8'h00));
    drive_word(req_word(1'b1, 7'h2A, 8'd0, 1'b0));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(req_word(1'b0, 7'h01, 8'd0, 1'b1));
    drive_word(core_word(1'b1, 8'h00));
    drive_word(core_word(1'b1, 8'h00));
    drain();

    items_sent = 0;
    burst_left = 0;
    held = 0;
    paused = 0;
    while (items_sent < RandomItems) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(0, 10));
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
      end
      random_step();
      burst_left--;
      if (!held && items_sent >= RandomItems / 3) begin
        hold_req = 1'b1;
        held = 1;
      end
      if (!paused && items_sent >= 2 * RandomItems / 3) begin
        drain();
        paused = 1;
      end
    end
    drain();

    $display("ran %0d transfers (%0d without address acknowledge) under random stalls,",
             sb.transfers, sb.nacks);
    $display("checked %0d result words, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int sel;
    int span;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      sel  = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int k = 0; k < span && !hold_req; k++) begin
        case (sel)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (k % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) sb.check(out_word);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d result words outstanding", sb.pending.size());
    $display("status: fail");
    $finish;
  end
endmodule
